// File: src/buffer_slot_allocator_core_defines.svh
// ----------------------------------------------------------------------------
// Slot allocator assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef BUFFER_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define BUFFER_SLOT_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication
`define BSA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slot allocator check failed");

// Next-cycle implication
`define BSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slot allocator check failed");

`endif

// File: src/bsa_pkg.sv
// ----------------------------------------------------------------------------
// Slot allocator package
// Beat types, operation and status codes for the slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int SLOT_W = 8;
  localparam int ARG_W  = 16;

  // Unused slot marker on the argument field
  localparam logic [ARG_W-1:0] SENTINEL_SLOT = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_RESET   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_IGNORED   = 2'd2
  } status_e;

  typedef struct packed {
    op_e              operation;
    logic [ARG_W-1:0] slot_or_mark;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    status_e           status;
  } out_item_t;

endpackage

// File: src/buffer_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// Buffer slot allocator core
// Free-list stack allocator with a bump cursor behind it.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; every command
// gives one result beat, shown for a single cycle with out_valid high, and the
// receiver must take it then: there is no back-pressure. Allocate pops the
// most recently released slot, else takes the bump cursor (stepping over the
// reserved slot) and reports exhaustion at the pool end. Release pushes a slot;
// bad releases are ignored. Reset-to-mark lowers the cursor and compacts the
// free stack in order. Timing: release, cursor allocate and ignored commands
// give their registered result in the cycle after start and busy stays low;
// an allocate from the stack reads the stack memory, holds busy in S_POP and
// registers the read entry as its result; a reset-to-mark walks the stack in
// S_CMP through its single read port and one write port before the result.
// The stack memory needs no clearing after reset: only entries below free_count
// are read.
// ----------------------------------------------------------------------------
`include "buffer_slot_allocator_core_defines.svh"

module buffer_slot_allocator_core
  import bsa_pkg::*;
#(
  parameter int POOL_SIZE     = 256,
  parameter int RESERVED_SLOT = 255
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_item,
  output logic      busy,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CNT_W = $clog2(POOL_SIZE + 1);
  localparam int CUR_W = $clog2(POOL_SIZE + 2);

  localparam logic [ARG_W-1:0] POOL_ARG = ARG_W'(POOL_SIZE);
  localparam logic [ARG_W-1:0] RSV_ARG  = ARG_W'(RESERVED_SLOT);
  localparam logic [CNT_W-1:0] POOL_CNT = CNT_W'(POOL_SIZE);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_CMP
  } state_t;

  state_t            state_r,      state_nxt;
  logic [CUR_W-1:0]  cursor_r,     cursor_nxt;
  logic [CNT_W-1:0]  free_count_r, free_count_nxt;
  logic [CNT_W-1:0]  rd_cnt_r,     rd_cnt_nxt;
  logic [CNT_W-1:0]  wr_cnt_r,     wr_cnt_nxt;
  logic              pend_r,       pend_nxt;
  logic              out_valid_r,  out_valid_nxt;
  out_item_t         out_item_r,   out_item_nxt;

  // Free stack storage
  logic [IDX_W-1:0]  mem [POOL_SIZE];
  logic [IDX_W-1:0]  rd_data_r;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [IDX_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;

  logic              accept;
  logic [ARG_W-1:0]  arg;
  logic [ARG_W-1:0]  cur_arg;
  logic [CUR_W-1:0]  bump;
  logic              release_bad;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign arg     = in_item.slot_or_mark;
  assign cur_arg = ARG_W'(cursor_r);

  // Bump candidate, stepping over the reserved slot
  assign bump = (cur_arg == RSV_ARG) ? cursor_r + CUR_W'(1) : cursor_r;

  assign release_bad = (arg == SENTINEL_SLOT) || (arg >= POOL_ARG) ||
                       (arg >= cur_arg) || (arg == RSV_ARG) ||
                       (free_count_r >= POOL_CNT);

  // Sequencer next-state and memory port control
  always_comb begin
    state_nxt      = state_r;
    cursor_nxt     = cursor_r;
    free_count_nxt = free_count_r;
    rd_cnt_nxt     = rd_cnt_r;
    wr_cnt_nxt     = wr_cnt_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = 1'b0;
    out_item_nxt   = out_item_r;
    mem_we         = 1'b0;
    mem_waddr      = IDX_W'(free_count_r);
    mem_wdata      = IDX_W'(arg);
    mem_re         = 1'b0;
    mem_raddr      = IDX_W'(rd_cnt_r);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{slot: '0, status: ST_IGNORED};
          case (in_item.operation)
            OP_ALLOC: begin
              if (free_count_r != '0) begin
                // Pop: read the top entry, result follows
                free_count_nxt = free_count_r - CNT_W'(1);
                mem_re         = 1'b1;
                mem_raddr      = IDX_W'(free_count_r - CNT_W'(1));
                out_valid_nxt  = 1'b0;
                state_nxt      = S_POP;
              end else if (ARG_W'(bump) >= POOL_ARG) begin
                cursor_nxt   = bump;
                out_item_nxt = '{slot: '0, status: ST_EXHAUSTED};
              end else begin
                cursor_nxt   = bump + CUR_W'(1);
                out_item_nxt = '{slot: SLOT_W'(bump), status: ST_DONE};
              end
            end
            OP_RELEASE: begin
              if (!release_bad) begin
                mem_we         = 1'b1;
                free_count_nxt = free_count_r + CNT_W'(1);
                out_item_nxt   = '{slot: '0, status: ST_DONE};
              end
            end
            OP_RESET: begin
              if (arg <= cur_arg) begin
                cursor_nxt    = CUR_W'(arg);
                rd_cnt_nxt    = '0;
                wr_cnt_nxt    = '0;
                pend_nxt      = 1'b0;
                out_valid_nxt = 1'b0;
                state_nxt     = S_CMP;
              end
            end
            default: begin
              out_item_nxt = '{slot: '0, status: ST_IGNORED};
            end
          endcase
        end
      end

      S_POP: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{slot: SLOT_W'(rd_data_r), status: ST_DONE};
        state_nxt     = S_IDLE;
      end

      S_CMP: begin
        // Issue the next read while entries remain
        if (rd_cnt_r != free_count_r) begin
          mem_re     = 1'b1;
          mem_raddr  = IDX_W'(rd_cnt_r);
          rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        // Keep an entry below the mark, packing it down
        if (pend_r && (CUR_W'(rd_data_r) < cursor_r)) begin
          mem_we     = 1'b1;
          mem_waddr  = IDX_W'(wr_cnt_r);
          mem_wdata  = rd_data_r;
          wr_cnt_nxt = wr_cnt_r + CNT_W'(1);
        end
        // Finish once the walk has drained
        if ((rd_cnt_r == free_count_r) && !pend_r) begin
          free_count_nxt = wr_cnt_r;
          out_valid_nxt  = 1'b1;
          out_item_nxt   = '{slot: '0, status: ST_DONE};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cursor_r     <= '0;
      free_count_r <= '0;
      rd_cnt_r     <= '0;
      wr_cnt_r     <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cursor_r     <= cursor_nxt;
      free_count_r <= free_count_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      wr_cnt_r     <= wr_cnt_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  // Free stack memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Checks
  `BSA_ASSERT_IMPL(a_count_bound, 1'b1, free_count_r <= POOL_CNT)
  `BSA_ASSERT_IMPL(a_pack_behind, state_r == S_CMP, wr_cnt_r <= rd_cnt_r)
  `BSA_ASSERT_NEXT(a_pop_result, state_r == S_POP, out_valid && (out_item.status == ST_DONE))
  `BSA_ASSERT_NEXT(a_release_quick, accept && (in_item.operation == OP_RELEASE), out_valid && !busy)

endmodule
